[hdl/lpp_pkg.sv]
// Shared constants and types for the line position PID block.
// Used by every module of the block; depends on nothing.
package lpp_pkg;

	localparam int SUM_BITS       = 24;
	localparam int GAIN_FRAC_BITS = 8;

	localparam int GAIN_W  = 16;
	localparam int MAG_W   = 7;
	localparam int DEV_W   = 8;
	localparam int DIFF_W  = DEV_W + 1;
	localparam int DRIVE_W = 16;
	localparam int PAT_W   = 7;
	localparam int IDX_W   = 3;
	localparam int ACC_W   = GAIN_W + SUM_BITS + 2;

	localparam logic [IDX_W-1:0] REG_KP           = 3'd0;
	localparam logic [IDX_W-1:0] REG_KI           = 3'd1;
	localparam logic [IDX_W-1:0] REG_KD           = 3'd2;
	localparam logic [IDX_W-1:0] REG_DEV_SLIGHT   = 3'd3;
	localparam logic [IDX_W-1:0] REG_DEV_MODERATE = 3'd4;
	localparam logic [IDX_W-1:0] REG_DEV_SERIOUS  = 3'd5;
	localparam logic [IDX_W-1:0] REG_DEV_EXTREME  = 3'd6;

	localparam logic [MAG_W-1:0] RST_DEV_SLIGHT   = 7'd1;
	localparam logic [MAG_W-1:0] RST_DEV_MODERATE = 7'd2;
	localparam logic [MAG_W-1:0] RST_DEV_SERIOUS  = 7'd4;
	localparam logic [MAG_W-1:0] RST_DEV_EXTREME  = 7'd8;

	typedef struct packed {
		logic signed [GAIN_W-1:0] kp;
		logic signed [GAIN_W-1:0] ki;
		logic signed [GAIN_W-1:0] kd;
		logic        [MAG_W-1:0]  dev_slight;
		logic        [MAG_W-1:0]  dev_moderate;
		logic        [MAG_W-1:0]  dev_serious;
		logic        [MAG_W-1:0]  dev_extreme;
	} cfg_t;

endpackage

[hdl/lpp_dev_map.sv]
// Sensor pattern decoder: maps a listed pattern to a signed deviation.
// Depends on lpp_pkg for widths and the configuration struct.
module lpp_dev_map import lpp_pkg::*; (
	input  logic        [PAT_W-1:0] pattern,
	input  cfg_t                    cfg,
	output logic                    hit,
	output logic signed [DEV_W-1:0] dev
);

	logic [MAG_W-1:0] mag;
	logic             left;

	always_comb begin
		hit  = 1'b1;
		left = 1'b0;
		mag  = '0;
		case (pattern)
			7'b0001000, 7'b0011100, 7'b0111110, 7'b1111111: begin
				mag = '0;
			end
			7'b0011000, 7'b0111100, 7'b1111110: begin
				mag = cfg.dev_slight; left = 1'b1;
			end
			7'b0001100, 7'b0011110, 7'b0111111: begin
				mag = cfg.dev_slight;
			end
			7'b0111000, 7'b1111100: begin
				mag = cfg.dev_moderate; left = 1'b1;
			end
			7'b0001110, 7'b0011111: begin
				mag = cfg.dev_moderate;
			end
			7'b0110000, 7'b1110000, 7'b1111000: begin
				mag = cfg.dev_serious; left = 1'b1;
			end
			7'b0000110, 7'b0000111, 7'b0001111: begin
				mag = cfg.dev_serious;
			end
			7'b0100000, 7'b1100000, 7'b1000000: begin
				mag = cfg.dev_extreme; left = 1'b1;
			end
			7'b0000010, 7'b0000011, 7'b0000001: begin
				mag = cfg.dev_extreme;
			end
			default: begin
				hit = 1'b0;
			end
		endcase
		dev = left ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	end

endmodule

[hdl/lpp_pid_core.sv]
// PID step: holds the integral and previous deviation and forms the drive word.
// Depends on lpp_pkg and instantiates lpp_dev_map.
module lpp_pid_core import lpp_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      advance,
	input  logic                      clear,
	input  logic        [PAT_W-1:0]   pattern,
	input  cfg_t                      cfg,
	output logic signed [DRIVE_W-1:0] drive_next,
	output logic signed [DEV_W-1:0]   dev_next
);

	localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
	localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};
	localparam logic signed [ACC_W-1:0] BIAS    = ACC_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);
	localparam logic signed [ACC_W-1:0] DRV_MAX = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0] DRV_MIN = ACC_W'(-32768);

	logic signed [SUM_BITS-1:0]        sum_q;
	logic signed [DEV_W-1:0]           last_dev_q;
	logic                              hit;
	logic signed [DEV_W-1:0]           map_dev;
	logic signed [DEV_W-1:0]           dev_sel;
	logic signed [SUM_BITS:0]          sum_ext;
	logic signed [SUM_BITS-1:0]        sum_new;
	logic signed [DIFF_W-1:0]          diff;
	logic signed [GAIN_W+DEV_W-1:0]    prod_p;
	logic signed [GAIN_W+SUM_BITS-1:0] prod_i;
	logic signed [GAIN_W+DIFF_W-1:0]   prod_d;
	logic signed [ACC_W-1:0]           acc;
	logic signed [ACC_W-1:0]           scaled;

	lpp_dev_map u_map (
		.pattern (pattern),
		.cfg     (cfg),
		.hit     (hit),
		.dev     (map_dev)
	);

	always_comb begin
		dev_sel = hit ? map_dev : last_dev_q;
		sum_ext = (SUM_BITS+1)'(sum_q) + (SUM_BITS+1)'(dev_sel);
		if (sum_ext[SUM_BITS] != sum_ext[SUM_BITS-1]) begin
			sum_new = sum_ext[SUM_BITS] ? SUM_MIN : SUM_MAX;
		end else begin
			sum_new = sum_ext[SUM_BITS-1:0];
		end
		diff   = DIFF_W'(dev_sel) - DIFF_W'(last_dev_q);
		prod_p = cfg.kp * dev_sel;
		prod_i = cfg.ki * sum_new;
		prod_d = cfg.kd * diff;
		acc    = ACC_W'(prod_p) + ACC_W'(prod_i) + ACC_W'(prod_d);
		// Rounding toward zero: negative values are biased before the shift.
		scaled = (acc + (acc[ACC_W-1] ? BIAS : ACC_W'(0))) >>> GAIN_FRAC_BITS;
		if (clear) begin
			drive_next = '0;
			dev_next   = '0;
		end else begin
			if (scaled > DRV_MAX) begin
				drive_next = DRIVE_W'(DRV_MAX);
			end else if (scaled < DRV_MIN) begin
				drive_next = DRIVE_W'(DRV_MIN);
			end else begin
				drive_next = scaled[DRIVE_W-1:0];
			end
			dev_next = dev_sel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q      <= '0;
			last_dev_q <= '0;
		end else if (advance) begin
			if (clear) begin
				sum_q      <= '0;
				last_dev_q <= '0;
			end else begin
				sum_q      <= sum_new;
				last_dev_q <= dev_sel;
			end
		end
	end

endmodule

[hdl/line_position_pid.sv]
// Line position PID top level: input register, PID step, result register.
// An accepted word is held in the input register, and its result in the result register.
// Throughput is one word per cycle while the output is not stalled; the PID state update is the only loop.
// Asynchronous reset clears the valid flags of both stages, the integral and the previous deviation,
// and returns the gains to zero and the deviation magnitudes to 1, 2, 4 and 8.
// Depends on lpp_pkg and lpp_pid_core.
module line_position_pid import lpp_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      req_type,
	input  logic        [PAT_W-1:0]   sensor_pattern,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [DRIVE_W-1:0] drive,
	output logic signed [DEV_W-1:0]   deviation,
	input  logic                      cfg_wen,
	input  logic        [IDX_W-1:0]   cfg_idx,
	input  logic        [GAIN_W-1:0]  cfg_wdata
);

	cfg_t                      cfg_q;
	logic                      valid_s1;
	logic                      clear_s1;
	logic        [PAT_W-1:0]   pattern_s1;
	logic                      valid_s2;
	logic signed [DRIVE_W-1:0] drive_s2;
	logic signed [DEV_W-1:0]   dev_s2;
	logic                      advance;
	logic signed [DRIVE_W-1:0] drive_next;
	logic signed [DEV_W-1:0]   dev_next;

	assign advance   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = valid_s2;
	assign drive     = drive_s2;
	assign deviation = dev_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp           <= '0;
			cfg_q.ki           <= '0;
			cfg_q.kd           <= '0;
			cfg_q.dev_slight   <= RST_DEV_SLIGHT;
			cfg_q.dev_moderate <= RST_DEV_MODERATE;
			cfg_q.dev_serious  <= RST_DEV_SERIOUS;
			cfg_q.dev_extreme  <= RST_DEV_EXTREME;
		end else if (cfg_wen) begin
			case (cfg_idx)
				REG_KP:           cfg_q.kp           <= cfg_wdata;
				REG_KI:           cfg_q.ki           <= cfg_wdata;
				REG_KD:           cfg_q.kd           <= cfg_wdata;
				REG_DEV_SLIGHT:   cfg_q.dev_slight   <= cfg_wdata[MAG_W-1:0];
				REG_DEV_MODERATE: cfg_q.dev_moderate <= cfg_wdata[MAG_W-1:0];
				REG_DEV_SERIOUS:  cfg_q.dev_serious  <= cfg_wdata[MAG_W-1:0];
				REG_DEV_EXTREME:  cfg_q.dev_extreme  <= cfg_wdata[MAG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			clear_s1   <= req_type;
			pattern_s1 <= sensor_pattern;
		end
	end

	lpp_pid_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.clear      (clear_s1),
		.pattern    (pattern_s1),
		.cfg        (cfg_q),
		.drive_next (drive_next),
		.dev_next   (dev_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || !out_stall) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			drive_s2 <= drive_next;
			dev_s2   <= dev_next;
		end
	end

endmodule

[hdl/lpp_checker.sv]
// Port-level checks for the line position PID block, bound to the top level.
// Depends on lpp_pkg for the port widths.
module lpp_checker import lpp_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic signed [DRIVE_W-1:0] drive,
	input logic signed [DEV_W-1:0]   deviation
);

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while the result register could drain");

	a_two_cycle_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall |=> out_valid)
		else $error("accepted word did not reach the output in two cycles");

	a_deviation_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (deviation != -8'sd128))
		else $error("deviation outside the magnitude range");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(drive) && $stable(deviation)))
		else $error("stalled result changed");

endmodule

bind line_position_pid lpp_checker u_lpp_checker (.*);

[tb/tb_line_position_pid.sv]
// Self-checking testbench for line_position_pid: random valid/stall traffic on both channels,
// configuration rewritten between phases, every result compared with a built-in PID predictor.
// Depends on lpp_pkg and the line_position_pid RTL.
module tb_line_position_pid;
	timeunit 1ns;
	timeprecision 1ps;

	import lpp_pkg::*;

	typedef struct packed {
		logic             clear;
		logic [PAT_W-1:0] pattern;
	} sensor_word_t;

	typedef struct packed {
		logic signed [DRIVE_W-1:0] drive;
		logic signed [DEV_W-1:0]   deviation;
	} correction_t;

	localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int     WATCHDOG_LIMIT = 2000;
	localparam int     SAT_WORDS      = 40;
	localparam int     RANDOM_PHASES  = 6;
	localparam int     PHASE_WORDS    = 150;
	localparam longint SUM_MAX        = (longint'(1) <<< (SUM_BITS - 1)) - 1;
	localparam longint SUM_MIN        = -SUM_MAX - 1;
	localparam longint GAIN_ONE       = longint'(1) <<< GAIN_FRAC_BITS;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic                      req_type = 1'b0;
	logic        [PAT_W-1:0]   sensor_pattern = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic signed [DRIVE_W-1:0] drive;
	logic signed [DEV_W-1:0]   deviation;
	logic                      cfg_wen = 1'b0;
	logic        [IDX_W-1:0]   cfg_idx = '0;
	logic        [GAIN_W-1:0]  cfg_wdata = '0;

	sensor_word_t pending_words[$];
	correction_t  expected_corrections[$];

	cfg_t   model_cfg = '{16'sd0, 16'sd0, 16'sd0, RST_DEV_SLIGHT, RST_DEV_MODERATE,
		RST_DEV_SERIOUS, RST_DEV_EXTREME};
	longint model_error_sum = 0;
	int     model_last_dev = 0;

	logic [PAT_W-1:0] listed_patterns [26] = '{
		7'h08, 7'h1C, 7'h3E, 7'h7F, 7'h18, 7'h3C, 7'h7E, 7'h0C, 7'h1E, 7'h3F,
		7'h38, 7'h7C, 7'h0E, 7'h1F, 7'h30, 7'h70, 7'h78, 7'h06, 7'h07, 7'h0F,
		7'h20, 7'h60, 7'h40, 7'h02, 7'h03, 7'h01};

	int errors = 0;
	int words_sent = 0;
	int clears_sent = 0;
	int unlisted_sent = 0;
	int saturated_drives = 0;
	int results_checked = 0;
	int settings_used = 1;
	int quiet_cycles = 0;
	int gap_left = 0;
	int calm_words = 0;
	int stall_left = 0;
	int calm_cycles = 0;
	bit fast_feed = 1'b0;

	line_position_pid dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.req_type       (req_type),
		.sensor_pattern (sensor_pattern),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.drive          (drive),
		.deviation      (deviation),
		.cfg_wen        (cfg_wen),
		.cfg_idx        (cfg_idx),
		.cfg_wdata      (cfg_wdata)
	);

	always #5ns clk = ~clk;

	function automatic bit map_sensor(input logic [PAT_W-1:0] pat, output int dev);
		bit hit;
		hit = 1'b1;
		case (pat)
		7'h08, 7'h1C, 7'h3E, 7'h7F: dev = 0;
		7'h18, 7'h3C, 7'h7E: dev = -int'(model_cfg.dev_slight);
		7'h0C, 7'h1E, 7'h3F: dev = int'(model_cfg.dev_slight);
		7'h38, 7'h7C: dev = -int'(model_cfg.dev_moderate);
		7'h0E, 7'h1F: dev = int'(model_cfg.dev_moderate);
		7'h30, 7'h70, 7'h78: dev = -int'(model_cfg.dev_serious);
		7'h06, 7'h07, 7'h0F: dev = int'(model_cfg.dev_serious);
		7'h20, 7'h60, 7'h40: dev = -int'(model_cfg.dev_extreme);
		7'h02, 7'h03, 7'h01: dev = int'(model_cfg.dev_extreme);
		default: begin
			dev = 0;
			hit = 1'b0;
		end
		endcase
		return hit;
	endfunction

	function automatic correction_t predict_correction(input sensor_word_t w);
		correction_t c;
		int          dev;
		longint      diff;
		longint      acc;
		longint      q;
		if (w.clear) begin
			model_error_sum = 0;
			model_last_dev = 0;
			clears_sent++;
			c.drive = '0;
			c.deviation = '0;
			return c;
		end
		if (!map_sensor(w.pattern, dev)) begin
			dev = model_last_dev;
			unlisted_sent++;
		end
		model_error_sum += dev;
		if (model_error_sum > SUM_MAX)
			model_error_sum = SUM_MAX;
		if (model_error_sum < SUM_MIN)
			model_error_sum = SUM_MIN;
		diff = dev - model_last_dev;
		model_last_dev = dev;
		acc = longint'($signed(model_cfg.kp)) * dev
			+ longint'($signed(model_cfg.ki)) * model_error_sum
			+ longint'($signed(model_cfg.kd)) * diff;
		q = acc / GAIN_ONE;
		if (q > 32767) begin
			q = 32767;
			saturated_drives++;
		end else if (q < -32768) begin
			q = -32768;
			saturated_drives++;
		end
		c.drive = q[DRIVE_W-1:0];
		c.deviation = dev[DEV_W-1:0];
		return c;
	endfunction

	function automatic int pick_gap();
		int r;
		if (fast_feed)
			return 0;
		if (calm_words > 0) begin
			calm_words--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			calm_words = $urandom_range(20, 80);
			return 0;
		end
		if (r < 70)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(0, 5))
		0: return 16'h7FFF;
		1: return 16'h8000;
		2: return '0;
		3: begin
			if ($urandom_range(0, 1) == 1)
				return GAIN_W'($urandom_range(0, 1023));
			return -GAIN_W'($urandom_range(0, 1023));
		end
		default: return GAIN_W'($urandom());
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] pick_magnitude();
		logic [GAIN_W-1:0] data;
		data = GAIN_W'($urandom());
		case ($urandom_range(0, 4))
		0: data[MAG_W-1:0] = 7'd127;
		1: data[MAG_W-1:0] = 7'd0;
		default: data[MAG_W-1:0] = MAG_W'($urandom_range(0, 127));
		endcase
		return data;
	endfunction

	function automatic sensor_word_t random_word();
		sensor_word_t w;
		int           r;
		r = $urandom_range(0, 99);
		w.clear = 1'b0;
		w.pattern = PAT_W'($urandom_range(0, 127));
		if (r < 4)
			w.clear = 1'b1;
		else if (r < 70)
			w.pattern = listed_patterns[$urandom_range(0, 25)];
		return w;
	endfunction

	function automatic void push_word(input logic clear, input logic [PAT_W-1:0] pat);
		sensor_word_t w;
		w.clear = clear;
		w.pattern = pat;
		pending_words.push_back(w);
	endfunction

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_wen <= 1'b0;
		case (idx)
		REG_KP: model_cfg.kp = data;
		REG_KI: model_cfg.ki = data;
		REG_KD: model_cfg.kd = data;
		REG_DEV_SLIGHT: model_cfg.dev_slight = data[MAG_W-1:0];
		REG_DEV_MODERATE: model_cfg.dev_moderate = data[MAG_W-1:0];
		REG_DEV_SERIOUS: model_cfg.dev_serious = data[MAG_W-1:0];
		REG_DEV_EXTREME: model_cfg.dev_extreme = data[MAG_W-1:0];
		default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic wait_idle();
		do begin
			@(negedge clk);
		end while (pending_words.size() != 0 || in_valid || expected_corrections.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic randomise_settings();
		write_reg(REG_KP, pick_gain());
		write_reg(REG_KI, pick_gain());
		write_reg(REG_KD, pick_gain());
		write_reg(REG_DEV_SLIGHT, pick_magnitude());
		write_reg(REG_DEV_MODERATE, pick_magnitude());
		write_reg(REG_DEV_SERIOUS, pick_magnitude());
		write_reg(REG_DEV_EXTREME, pick_magnitude());
		if ($urandom_range(0, 1) == 1)
			write_reg(REG_UNUSED, GAIN_W'($urandom()));
		settings_used++;
	endtask

	always @(posedge clk) begin : drive_words
		sensor_word_t w;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				w.clear = req_type;
				w.pattern = sensor_pattern;
				expected_corrections.push_back(predict_correction(w));
				words_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_words.size() != 0) begin
					w = pending_words.pop_front();
					req_type <= w.clear;
					sensor_pattern <= w.pattern;
					in_valid <= 1'b1;
					gap_left = pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : stall_results
		int r;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			if (calm_cycles > 0) begin
				calm_cycles--;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 2)
					calm_cycles = $urandom_range(50, 150);
				else if (r < 7)
					stall_left = $urandom_range(1, 3);
				else if (r < 9)
					stall_left = $urandom_range(4, 10);
				else if (r < 10)
					stall_left = $urandom_range(20, 60);
			end
		end
	end

	always @(posedge clk) begin : check_results
		correction_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_checked++;
			if (expected_corrections.size() == 0) begin
				$display("%0t: unexpected result, drive %0d deviation %0d", $time, drive,
					deviation);
				errors++;
			end else begin
				want = expected_corrections.pop_front();
				if (drive !== want.drive) begin
					$display("%0t: drive mismatch, expected %0d, actual %0d", $time,
						want.drive, drive);
					errors++;
				end
				if (deviation !== want.deviation) begin
					$display("%0t: deviation mismatch, expected %0d, actual %0d", $time,
						want.deviation, deviation);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wen)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int r;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset magnitudes, one pattern of each class, an unlisted pattern and a clear.
		push_word(1'b0, 7'h08);
		push_word(1'b0, 7'h18);
		push_word(1'b0, 7'h0C);
		push_word(1'b0, 7'h38);
		push_word(1'b0, 7'h0E);
		push_word(1'b0, 7'h30);
		push_word(1'b0, 7'h06);
		push_word(1'b0, 7'h40);
		push_word(1'b0, 7'h01);
		push_word(1'b0, 7'h00);
		push_word(1'b1, 7'h7F);
		wait_idle();

		// Extreme gains and magnitudes, with a write to the unused index that must be ignored.
		write_reg(REG_KP, 16'h7FFF);
		write_reg(REG_KI, 16'h8000);
		write_reg(REG_KD, 16'h7FFF);
		write_reg(REG_DEV_SLIGHT, 16'hFFFF);
		write_reg(REG_DEV_MODERATE, 16'hFF80);
		write_reg(REG_DEV_SERIOUS, 16'h0040);
		write_reg(REG_DEV_EXTREME, 16'h007F);
		write_reg(REG_UNUSED, 16'h5A5A);
		settings_used++;
		push_word(1'b0, 7'h01);
		push_word(1'b0, 7'h40);
		push_word(1'b0, 7'h55);
		push_word(1'b0, 7'h00);
		push_word(1'b0, 7'h7F);
		push_word(1'b0, 7'h0E);
		push_word(1'b0, 7'h0F);
		push_word(1'b0, 7'h3C);
		push_word(1'b1, 7'h01);
		push_word(1'b0, 7'h03);
		wait_idle();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			randomise_settings();
			repeat (PHASE_WORDS) pending_words.push_back(random_word());
			wait_idle();
		end

		// Push the integral hard to the right, then hard to the left, with no input gaps.
		fast_feed = 1'b1;
		write_reg(REG_KP, pick_gain());
		write_reg(REG_KI, 16'h0100);
		write_reg(REG_KD, pick_gain());
		write_reg(REG_DEV_EXTREME, 16'h007F);
		settings_used++;
		push_word(1'b1, 7'h00);
		push_word(1'b0, 7'h01);
		repeat (SAT_WORDS) begin
			r = $urandom_range(0, 99);
			push_word(1'b0, (r < 5) ? 7'h55 : PAT_W'($urandom_range(1, 3)));
		end
		push_word(1'b1, 7'h00);
		push_word(1'b0, 7'h40);
		repeat (SAT_WORDS) begin
			r = $urandom_range(0, 99);
			push_word(1'b0, (r < 5) ? 7'h55 : PAT_W'({$urandom_range(1, 3), 5'b00000}));
		end
		push_word(1'b1, 7'h00);
		wait_idle();
		fast_feed = 1'b0;
		repeat (10) @(negedge clk);

		$display("Sent %0d words (%0d clears, %0d unlisted patterns) under %0d register settings.",
			words_sent, clears_sent, unlisted_sent, settings_used);
		$display("Checked %0d results; %0d drives were clipped to the output range.",
			results_checked, saturated_drives);
		if (errors == 0 && expected_corrections.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
